// ===== rtl/complex_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared check templates; every check is clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication check
`define CAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau: same-cycle check failed");

// Next-cycle implication check
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cau: next-cycle check failed");

`endif

// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and saturation helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    op_t   opcode;
    word_t a_real;
    word_t a_imag;
    word_t b_real;
    word_t b_imag;
  } in_t;

  typedef struct packed {
    word_t   result_real;
    word_t   result_imag;
    status_t status;
  } out_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sat_word_t;

  localparam logic signed [SUM_BITS-1:0] SAT_MAX =
    {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SAT_MIN =
    {{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] HALF_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Clamp a wide signed value to the word range.
  function automatic sat_word_t sat_fn(input logic signed [SUM_BITS-1:0] v);
    sat_word_t r;
    if (v > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = SAT_MAX[WORD_BITS-1:0];
    end else if (v < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = SAT_MIN[WORD_BITS-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Apply sign and clamp to a quotient magnitude.
  function automatic sat_word_t div_fin(input logic [WORD_BITS-1:0] q,
                                        input logic ovf, input logic neg);
    sat_word_t r;
    if (!neg) begin
      r.sat = ovf || q[WORD_BITS-1];
      r.val = r.sat ? SAT_MAX[WORD_BITS-1:0] : q;
    end else begin
      r.sat = ovf || (q > HALF_MAG);
      r.val = r.sat ? SAT_MIN[WORD_BITS-1:0] : (-q);
    end
    return r;
  endfunction

endpackage

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 words.
// ----------------------------------------------------------------------------
// Registers from accept to out_valid: s1, s2, the divider stages dv[0..WORD_BITS], output.
// Throughput: one item per cycle while out_stall does not hold the pipe; depth is set
// by the radix-2 restoring divider, which resolves one quotient bit per pipeline stage.
// Reset: synchronous, active low; clears every stage valid bit, data is kept.
// Empty stages close up under out_stall, so input keeps flowing into bubbles.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int NUM_BITS = PROD_BITS + FRAC_BITS;
  localparam int CMP_BITS = PROD_BITS + WORD_BITS;

  // Stage 1: products, squares and the finished add/sub result
  typedef struct packed {
    op_t                         op;
    logic signed [PROD_BITS-1:0] p_rr;
    logic signed [PROD_BITS-1:0] p_ii;
    logic signed [PROD_BITS-1:0] p_ir;
    logic signed [PROD_BITS-1:0] p_ri;
    logic signed [PROD_BITS-1:0] sq_re;
    logic signed [PROD_BITS-1:0] sq_im;
    word_t                       as_re;
    word_t                       as_im;
    logic                        as_sat;
  } s1_t;

  // Stage 2: cross sums and divisor
  typedef struct packed {
    op_t                         op;
    logic signed [SUM_BITS-1:0]  sum_re;
    logic signed [SUM_BITS-1:0]  sum_im;
    logic [PROD_BITS-1:0]        den;
    word_t                       as_re;
    word_t                       as_im;
    logic                        as_sat;
  } s2_t;

  // Divider stages; non-divide items ride along with their finished result
  typedef struct packed {
    logic                 is_div;
    logic                 dz;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 neg_re;
    logic                 neg_im;
    logic [PROD_BITS-1:0] den;
    logic [PROD_BITS-1:0] rem_re;
    logic [PROD_BITS-1:0] rem_im;
    logic [WORD_BITS-1:0] nlo_re;
    logic [WORD_BITS-1:0] nlo_im;
    logic [WORD_BITS-1:0] q_re;
    logic [WORD_BITS-1:0] q_im;
    word_t                res_re;
    word_t                res_im;
    status_t              status;
  } dv_t;

  s1_t  s1_r, s1_nxt;
  logic s1_v_r;
  s2_t  s2_r, s2_nxt;
  logic s2_v_r;
  dv_t  dv_r   [0:WORD_BITS];
  dv_t  dv_nxt [0:WORD_BITS];
  logic dv_v_r [0:WORD_BITS];
  out_t out_data_r, out_data_nxt;
  logic out_valid_r;

  logic free_out, free_s1, free_s2;
  logic free_dv [0:WORD_BITS];

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its item moves on
  // --------------------------------------------------------------------------
  assign free_out           = !out_valid_r || !out_stall;
  assign free_dv[WORD_BITS] = !dv_v_r[WORD_BITS] || free_out;

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_free
    assign free_dv[k] = !dv_v_r[k] || free_dv[k+1];
  end

  assign free_s2  = !s2_v_r || free_dv[0];
  assign free_s1  = !s1_v_r || free_s2;
  assign in_stall = !free_s1;

  // --------------------------------------------------------------------------
  // Stage 1: six multipliers plus saturating add/sub
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [SUM_BITS-1:0] ar, ai, br, bi;
    sat_word_t                  sr, si;
    ar = SUM_BITS'(in_data.a_real);
    ai = SUM_BITS'(in_data.a_imag);
    br = SUM_BITS'(in_data.b_real);
    bi = SUM_BITS'(in_data.b_imag);
    if (in_data.opcode == OP_SUB) begin
      sr = sat_fn(ar - br);
      si = sat_fn(ai - bi);
    end else begin
      sr = sat_fn(ar + br);
      si = sat_fn(ai + bi);
    end
    s1_nxt.op     = in_data.opcode;
    s1_nxt.p_rr   = PROD_BITS'(in_data.a_real) * PROD_BITS'(in_data.b_real);
    s1_nxt.p_ii   = PROD_BITS'(in_data.a_imag) * PROD_BITS'(in_data.b_imag);
    s1_nxt.p_ir   = PROD_BITS'(in_data.a_imag) * PROD_BITS'(in_data.b_real);
    s1_nxt.p_ri   = PROD_BITS'(in_data.a_real) * PROD_BITS'(in_data.b_imag);
    s1_nxt.sq_re  = PROD_BITS'(in_data.b_real) * PROD_BITS'(in_data.b_real);
    s1_nxt.sq_im  = PROD_BITS'(in_data.b_imag) * PROD_BITS'(in_data.b_imag);
    s1_nxt.as_re  = sr.val;
    s1_nxt.as_im  = si.val;
    s1_nxt.as_sat = sr.sat || si.sat;
  end

  // --------------------------------------------------------------------------
  // Stage 2: multiply forms rr-ii / ir+ri, divide forms rr+ii / ir-ri
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [SUM_BITS-1:0] rr, ii, ir, ri;
    rr = SUM_BITS'(s1_r.p_rr);
    ii = SUM_BITS'(s1_r.p_ii);
    ir = SUM_BITS'(s1_r.p_ir);
    ri = SUM_BITS'(s1_r.p_ri);
    s2_nxt.op = s1_r.op;
    if (s1_r.op == OP_MUL) begin
      s2_nxt.sum_re = rr - ii;
      s2_nxt.sum_im = ir + ri;
    end else begin
      s2_nxt.sum_re = rr + ii;
      s2_nxt.sum_im = ir - ri;
    end
    // Both squares are non-negative and at most 2^(2W-2): the sum fits
    s2_nxt.den    = $unsigned(s1_r.sq_re) + $unsigned(s1_r.sq_im);
    s2_nxt.as_re  = s1_r.as_re;
    s2_nxt.as_im  = s1_r.as_im;
    s2_nxt.as_sat = s1_r.as_sat;
  end

  // --------------------------------------------------------------------------
  // Stage 3: finish multiply, pass on the add/sub result, set up the divider
  // --------------------------------------------------------------------------
  always_comb begin
    logic [SUM_BITS-1:0] mag_re, mag_im;
    logic [NUM_BITS-1:0] num_re, num_im;
    sat_word_t           mr, mi;
    mag_re = s2_r.sum_re[SUM_BITS-1] ? $unsigned(-s2_r.sum_re) : $unsigned(s2_r.sum_re);
    mag_im = s2_r.sum_im[SUM_BITS-1] ? $unsigned(-s2_r.sum_im) : $unsigned(s2_r.sum_im);
    num_re = {mag_re[PROD_BITS-1:0], {FRAC_BITS{1'b0}}};
    num_im = {mag_im[PROD_BITS-1:0], {FRAC_BITS{1'b0}}};
    // Multiply drops the fraction with an arithmetic shift (floor)
    mr = sat_fn(s2_r.sum_re >>> FRAC_BITS);
    mi = sat_fn(s2_r.sum_im >>> FRAC_BITS);

    dv_nxt[0].is_div = (s2_r.op == OP_DIV);
    dv_nxt[0].dz     = (s2_r.den == '0);
    // Quotient needs more than WORD_BITS bits: clamp regardless of low bits
    dv_nxt[0].ovf_re = CMP_BITS'(num_re) >= (CMP_BITS'(s2_r.den) << WORD_BITS);
    dv_nxt[0].ovf_im = CMP_BITS'(num_im) >= (CMP_BITS'(s2_r.den) << WORD_BITS);
    dv_nxt[0].neg_re = s2_r.sum_re[SUM_BITS-1];
    dv_nxt[0].neg_im = s2_r.sum_im[SUM_BITS-1];
    dv_nxt[0].den    = s2_r.den;
    dv_nxt[0].rem_re = PROD_BITS'(num_re >> WORD_BITS);
    dv_nxt[0].rem_im = PROD_BITS'(num_im >> WORD_BITS);
    dv_nxt[0].nlo_re = num_re[WORD_BITS-1:0];
    dv_nxt[0].nlo_im = num_im[WORD_BITS-1:0];
    dv_nxt[0].q_re   = '0;
    dv_nxt[0].q_im   = '0;
    if (s2_r.op == OP_MUL) begin
      dv_nxt[0].res_re = mr.val;
      dv_nxt[0].res_im = mi.val;
      dv_nxt[0].status = (mr.sat || mi.sat) ? ST_SAT : ST_OK;
    end else begin
      dv_nxt[0].res_re = s2_r.as_re;
      dv_nxt[0].res_im = s2_r.as_im;
      dv_nxt[0].status = s2_r.as_sat ? ST_SAT : ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one restoring step per stage on both parts
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= WORD_BITS; k++) begin : g_div
    always_comb begin
      logic [PROD_BITS-1:0] sh_re, sh_im;
      logic                 ge_re, ge_im;
      sh_re = {dv_r[k-1].rem_re[PROD_BITS-2:0], dv_r[k-1].nlo_re[WORD_BITS-1]};
      sh_im = {dv_r[k-1].rem_im[PROD_BITS-2:0], dv_r[k-1].nlo_im[WORD_BITS-1]};
      ge_re = sh_re >= dv_r[k-1].den;
      ge_im = sh_im >= dv_r[k-1].den;
      dv_nxt[k]        = dv_r[k-1];
      dv_nxt[k].rem_re = ge_re ? (sh_re - dv_r[k-1].den) : sh_re;
      dv_nxt[k].rem_im = ge_im ? (sh_im - dv_r[k-1].den) : sh_im;
      dv_nxt[k].nlo_re = {dv_r[k-1].nlo_re[WORD_BITS-2:0], 1'b0};
      dv_nxt[k].nlo_im = {dv_r[k-1].nlo_im[WORD_BITS-2:0], 1'b0};
      dv_nxt[k].q_re   = {dv_r[k-1].q_re[WORD_BITS-2:0], ge_re};
      dv_nxt[k].q_im   = {dv_r[k-1].q_im[WORD_BITS-2:0], ge_im};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (free_dv[k]) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (free_dv[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output: sign and clamp the quotients, pick the divide-by-zero case
  // --------------------------------------------------------------------------
  always_comb begin
    sat_word_t qr, qi;
    qr = div_fin(dv_r[WORD_BITS].q_re, dv_r[WORD_BITS].ovf_re, dv_r[WORD_BITS].neg_re);
    qi = div_fin(dv_r[WORD_BITS].q_im, dv_r[WORD_BITS].ovf_im, dv_r[WORD_BITS].neg_im);
    if (!dv_r[WORD_BITS].is_div) begin
      out_data_nxt.result_real = dv_r[WORD_BITS].res_re;
      out_data_nxt.result_imag = dv_r[WORD_BITS].res_im;
      out_data_nxt.status      = dv_r[WORD_BITS].status;
    end else if (dv_r[WORD_BITS].dz) begin
      out_data_nxt.result_real = '0;
      out_data_nxt.result_imag = '0;
      out_data_nxt.status      = ST_DIV0;
    end else begin
      out_data_nxt.result_real = qr.val;
      out_data_nxt.result_imag = qi.val;
      out_data_nxt.status      = (qr.sat || qi.sat) ? ST_SAT : ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Registers: valid bits reset, payload only advances
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      dv_v_r[0]   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free_s1) begin
        s1_v_r <= in_valid;
      end
      if (free_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (free_dv[0]) begin
        dv_v_r[0] <= s2_v_r;
      end
      if (free_out) begin
        out_valid_r <= dv_v_r[WORD_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_s1) begin
      s1_r <= s1_nxt;
    end
    if (free_s2) begin
      s2_r <= s2_nxt;
    end
    if (free_dv[0]) begin
      dv_r[0] <= dv_nxt[0];
    end
    if (free_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // Input is held off only when the whole pipe is full behind a stalled output
  `CAU_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid_r && out_stall)
  // A finished item moves into a free output register
  `CAU_ASSERT_NEXT(a_last_stage_drains, dv_v_r[WORD_BITS] && free_out, out_valid_r)
  // Divide by zero always yields zero parts
  `CAU_ASSERT_NOW(a_div0_zero, out_valid_r && (out_data_r.status == ST_DIV0),
                  (out_data_r.result_real == '0) && (out_data_r.result_imag == '0))

endmodule

// ===== sim/complex_arithmetic_unit_test.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test
// Drives directed and random complex add, subtract, multiply and divide items
// through the unit under bursty input and a random output stall pattern, and
// checks every result against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  // Cycles with no item moving on either side before the run is declared hung
  localparam int HANG_LIMIT = 5000;
  // Drain time after the last result: well over the pipeline depth
  localparam int TAIL_CYCLES = 2 * (WORD_BITS + 3) + 10;

  localparam longint WORD_MAX = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) << (WORD_BITS - 1));
  localparam word_t W_MAX = word_t'(WORD_MAX);
  localparam word_t W_MIN = word_t'(WORD_MIN);
  localparam word_t W_ONE = word_t'(longint'(1) << FRAC_BITS);

  // Receiver behavior, switched at random times
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKED} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  pending_ops[$];
  out_t expected_results[$];
  out_t want;

  logic     in_taken = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_mode_left = 0;

  int items_total = 0;
  int items_taken = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int errors = 0;
  int op_seen[4] = '{default: 0};
  int status_seen[4] = '{default: 0};

  complex_arithmetic_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp to the signed word range; flag the clip
  function automatic word_t clamp_word(input longint v, inout bit clipped);
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return W_MAX;
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return W_MIN;
    end
    return word_t'(v);
  endfunction

  // Expected result of one operation
  function automatic out_t cplx_predict(input in_t x);
    longint ar, ai, br, bi, den, nr, ni;
    bit     clipped;
    out_t   r;
    ar = x.a_real;
    ai = x.a_imag;
    br = x.b_real;
    bi = x.b_imag;
    clipped = 1'b0;
    r.result_real = '0;
    r.result_imag = '0;
    r.status = ST_OK;
    case (x.opcode)
      OP_ADD: begin
        r.result_real = clamp_word(ar + br, clipped);
        r.result_imag = clamp_word(ai + bi, clipped);
      end
      OP_SUB: begin
        r.result_real = clamp_word(ar - br, clipped);
        r.result_imag = clamp_word(ai - bi, clipped);
      end
      OP_MUL: begin
        // Exact products, then an arithmetic shift: rounds toward minus infinity
        r.result_real = clamp_word((ar * br - ai * bi) >>> FRAC_BITS, clipped);
        r.result_imag = clamp_word((ai * br + ar * bi) >>> FRAC_BITS, clipped);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          // Multiply by the conjugate, scale up, divide truncating toward zero
          nr = (ar * br + ai * bi) * (longint'(1) << FRAC_BITS);
          ni = (ai * br - ar * bi) * (longint'(1) << FRAC_BITS);
          r.result_real = clamp_word(nr / den, clipped);
          r.result_imag = clamp_word(ni / den, clipped);
        end
      end
    endcase
    if (r.status == ST_OK && clipped)
      r.status = ST_SAT;
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom);
      4, 5, 6:    return word_t'(int'($urandom_range(0, 2048)) - 1024);
      7: begin
        case ($urandom_range(0, 6))
          0: return W_MAX;
          1: return W_MIN;
          2: return word_t'(0);
          3: return word_t'(1);
          4: return word_t'(-1);
          5: return W_ONE;
          default: return -W_ONE;
        endcase
      end
      8: begin
        // Signed power of two anywhere in the word
        if ($urandom_range(0, 1) != 0)
          return word_t'(longint'(1) << $urandom_range(0, WORD_BITS - 2));
        return -word_t'(longint'(1) << $urandom_range(0, WORD_BITS - 1));
      end
      default: return word_t'(0);
    endcase
  endfunction

  task automatic queue_op(input op_t op, input word_t ar, input word_t ai,
                          input word_t br, input word_t bi);
    in_t x;
    x.opcode = op;
    x.a_real = ar;
    x.a_imag = ai;
    x.b_real = br;
    x.b_imag = bi;
    pending_ops.push_back(x);
  endtask

  // Driver: advance to the next item only once the held one was taken; hold
  // bursts of random length with random gaps between them.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        in_data <= pending_ops.pop_front();
        in_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          // Now and then a long back-to-back run with no gap at all
          if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: free, light, heavy or nearly blocked stretches
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left = rx_mode_left - 1;
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:  out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // Monitor: predict on every accepted item, check every accepted result in
  // order, and watch for a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(cplx_predict(in_data));
        op_seen[in_data.opcode] = op_seen[in_data.opcode] + 1;
        items_taken = items_taken + 1;
      end
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: real %0d imag %0d status %0d",
                 out_data.result_real, out_data.result_imag, out_data.status);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          status_seen[want.status] = status_seen[want.status] + 1;
          if (out_data.result_real !== want.result_real) begin
            $error("result_real: expected %0d, got %0d",
                   want.result_real, out_data.result_real);
            errors = errors + 1;
          end
          if (out_data.result_imag !== want.result_imag) begin
            $error("result_imag: expected %0d, got %0d",
                   want.result_imag, out_data.result_imag);
            errors = errors + 1;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors = errors + 1;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Hang: no item moved for %0d cycles", HANG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    in_t x;
    // Add and subtract: saturation in both directions and plain results
    queue_op(OP_ADD, W_MAX, W_MAX, W_MAX, W_MAX);
    queue_op(OP_ADD, W_MIN, W_MIN, W_MIN, W_MIN);
    queue_op(OP_ADD, W_ONE, -(W_ONE >>> 1), word_t'(512), word_t'(64));
    queue_op(OP_SUB, W_MAX, W_MIN, W_MIN, W_MAX);
    queue_op(OP_SUB, word_t'(0), word_t'(-1), word_t'(1), word_t'(-1));
    queue_op(OP_SUB, W_MIN, W_MAX, word_t'(0), word_t'(0));
    // Multiply: unity, floor rounding of a negative, positive saturation
    queue_op(OP_MUL, W_ONE, word_t'(0), W_ONE, word_t'(0));
    queue_op(OP_MUL, word_t'(-1), word_t'(1), word_t'(1), word_t'(1));
    queue_op(OP_MUL, W_MAX, word_t'(0), W_MAX, word_t'(0));
    queue_op(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
    queue_op(OP_MUL, W_MIN, W_MAX, W_MAX, W_MIN);
    queue_op(OP_MUL, word_t'(-3), word_t'(5), word_t'(7), word_t'(-2));
    // Divide by zero, with and without a zero dividend
    queue_op(OP_DIV, word_t'(1234), W_MIN, word_t'(0), word_t'(0));
    queue_op(OP_DIV, word_t'(0), word_t'(0), word_t'(0), word_t'(0));
    // Divide: unity, truncation toward zero, overflow, edge quotients
    queue_op(OP_DIV, W_ONE, word_t'(0), W_ONE, word_t'(0));
    queue_op(OP_DIV, word_t'(-1), word_t'(1), word_t'(768), word_t'(0));
    queue_op(OP_DIV, W_MAX, W_MAX, word_t'(1), word_t'(0));
    queue_op(OP_DIV, W_MIN, word_t'(0), -W_ONE, word_t'(0));
    queue_op(OP_DIV, W_MIN, word_t'(0), W_ONE, word_t'(0));
    queue_op(OP_DIV, W_MAX, W_MIN, W_MIN, W_MIN);
    queue_op(OP_DIV, word_t'(0), W_ONE, word_t'(0), W_ONE);
    queue_op(OP_DIV, word_t'(-700), word_t'(333), word_t'(-5), word_t'(9));

    // Random part: uniform opcodes, operands mixing full-range, small,
    // extreme and power-of-two values; divisors forced to zero now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      x.opcode = op_t'($urandom_range(0, 3));
      x.a_real = rand_word();
      x.a_imag = rand_word();
      x.b_real = rand_word();
      x.b_imag = rand_word();
      if (x.opcode == OP_DIV && $urandom_range(0, 11) == 0) begin
        x.b_real = '0;
        x.b_imag = '0;
      end
      pending_ops.push_back(x);
    end
    items_total = pending_ops.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every item in, every result out, then let stray output show up
    while (items_taken != items_total || results_seen != items_taken)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d items: add %0d, subtract %0d, multiply %0d, divide %0d",
             items_taken, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
             op_seen[OP_DIV]);
    $display("Results checked %0d: plain %0d, saturated %0d, divide by zero %0d",
             results_seen, status_seen[ST_OK], status_seen[ST_SAT],
             status_seen[ST_DIV0]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
